@@ rtl/cskfw_pkg.sv @@
package cskfw_pkg;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int NUM_KEY_REGS = 3;

  localparam logic [1:0] OP_PLOT    = 2'd0;
  localparam logic [1:0] OP_SPRITE  = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_WIDTH     = 3'd2;
  localparam logic [2:0] REG_HEIGHT    = 3'd3;
  localparam logic [2:0] REG_KEY_COUNT = 3'd4;
  localparam logic [2:0] REG_KEY_FIRST = 3'd5;
  localparam logic [2:0] REG_KEY_SECOND = 3'd6;
  localparam logic [2:0] REG_KEY_THIRD = 3'd7;

  localparam logic [10:0] SPRITE_DIM_MAX = 11'd1024;

  typedef struct packed {
    logic [11:0]                    origin_x;
    logic [11:0]                    origin_y;
    logic [10:0]                    width;
    logic [10:0]                    height;
    logic [1:0]                     key_count;
    logic [NUM_KEY_REGS-1:0][23:0]  keys;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic take;
    logic look;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/cskfw_ram.sv @@
module cskfw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/cskfw_regs.sv @@
module cskfw_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cskfw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cskfw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cskfw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output cskfw_pkg::cfg_t                cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x  <= '0;
      cfg.origin_y  <= '0;
      cfg.width     <= 11'd1;
      cfg.height    <= 11'd1;
      cfg.key_count <= '0;
      cfg.keys      <= '0;
    end else if (wr) begin
      unique case (idx)
        cskfw_pkg::REG_ORIGIN_X:   cfg.origin_x  <= pwdata[11:0];
        cskfw_pkg::REG_ORIGIN_Y:   cfg.origin_y  <= pwdata[11:0];
        cskfw_pkg::REG_WIDTH:      cfg.width     <= pwdata[10:0];
        cskfw_pkg::REG_HEIGHT:     cfg.height    <= pwdata[10:0];
        cskfw_pkg::REG_KEY_COUNT:  cfg.key_count <= pwdata[1:0];
        cskfw_pkg::REG_KEY_FIRST:  cfg.keys[0]   <= pwdata[23:0];
        cskfw_pkg::REG_KEY_SECOND: cfg.keys[1]   <= pwdata[23:0];
        cskfw_pkg::REG_KEY_THIRD:  cfg.keys[2]   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      cskfw_pkg::REG_ORIGIN_X:   prdata = 32'(cfg.origin_x);
      cskfw_pkg::REG_ORIGIN_Y:   prdata = 32'(cfg.origin_y);
      cskfw_pkg::REG_WIDTH:      prdata = 32'(cfg.width);
      cskfw_pkg::REG_HEIGHT:     prdata = 32'(cfg.height);
      cskfw_pkg::REG_KEY_COUNT:  prdata = 32'(cfg.key_count);
      cskfw_pkg::REG_KEY_FIRST:  prdata = 32'(cfg.keys[0]);
      cskfw_pkg::REG_KEY_SECOND: prdata = 32'(cfg.keys[1]);
      cskfw_pkg::REG_KEY_THIRD:  prdata = 32'(cfg.keys[2]);
      default:                   prdata = '0;
    endcase
  end

endmodule

@@ rtl/cskfw_ctrl.sv @@
module cskfw_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  cskfw_pkg::dp_stat_t    stat,
  output cskfw_pkg::ctrl_cmd_t   cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CALC  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.look   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.take, cmd.look, cmd.finish}))
    else $error("more than one datapath command at once");

  a_take_then_look: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> cmd.look)
    else $error("accepted beat not followed by frame lookup");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> stat.out_free)
    else $error("result loaded over an unclaimed result");

  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.clear && stat.clear_last) |=> (!cmd.clear && !in_stall))
    else $error("clear pass did not end at last entry");
`endif

endmodule

@@ rtl/cskfw_dp.sv @@
module cskfw_dp #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256,
  parameter int MAX_KEYS     = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cskfw_pkg::ctrl_cmd_t  cmd,
  output cskfw_pkg::dp_stat_t   stat,
  input  cskfw_pkg::cfg_t       cfg,
  input  logic [1:0]            opcode,
  input  logic signed [11:0]    pos_x,
  input  logic signed [11:0]    pos_y,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic [7:0]            alpha,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  in_frame,
  output logic                  was_keyed,
  output logic                  changed,
  output logic                  sprite_done,
  output logic [31:0]           read_color,
  output logic [31:0]           update_total,
  output logic [31:0]           call_total
);

  localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ADDR_W-1:0] clr_addr;

  logic [1:0]        op_r;
  logic [11:0]       px_r;
  logic [11:0]       py_r;
  logic [31:0]       color_r;

  logic [9:0]        col;
  logic [9:0]        row;

  logic signed [12:0] tx;
  logic signed [12:0] ty;
  logic               fin_c;
  logic               hit_c;
  logic [21:0]        lin;
  logic [23:0]        rgb;

  logic               fin_r;
  logic               keyed_r;
  logic [ADDR_W-1:0]  addr_r;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [31:0]        ram_wdata;
  logic [31:0]        ram_rdata;

  logic               wr_ok;
  logic               chg;
  logic [10:0]        eff_w;
  logic [10:0]        eff_h;
  logic [10:0]        col_inc;
  logic [10:0]        row_inc;
  logic               col_wrap;
  logic               row_wrap;

  assign stat.clear_last = (clr_addr == ADDR_W'(DEPTH - 1));
  assign stat.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r    <= opcode;
      px_r    <= pos_x;
      py_r    <= pos_y;
      color_r <= {alpha, blue, green, red};
    end
  end

  // target position and key match
  assign rgb = {color_r[7:0], color_r[15:8], color_r[23:16]};

  always_comb begin
    if (op_r == cskfw_pkg::OP_SPRITE) begin
      tx = $signed({cfg.origin_x[11], cfg.origin_x}) + $signed({3'b000, col});
      ty = $signed({cfg.origin_y[11], cfg.origin_y}) + $signed({3'b000, row});
    end else begin
      tx = $signed({px_r[11], px_r});
      ty = $signed({py_r[11], py_r});
    end
  end

  assign fin_c = (tx >= 13'sd0) && (tx < $signed(13'(FRAME_WIDTH)))
              && (ty >= 13'sd0) && (ty < $signed(13'(FRAME_HEIGHT)));

  assign lin = {11'b0, ty[10:0]} * 22'(FRAME_WIDTH) + {11'b0, tx[10:0]};

  always_comb begin
    hit_c = 1'b0;
    for (int k = 0; k < MAX_KEYS; k++) begin
      if ((2'(k) < cfg.key_count) && (cfg.keys[k] == rgb)) begin
        hit_c = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      fin_r   <= fin_c;
      keyed_r <= hit_c && (op_r == cskfw_pkg::OP_SPRITE);
      addr_r  <= lin[ADDR_W-1:0];
    end
  end

  // frame store
  assign wr_ok = fin_r && ((op_r == cskfw_pkg::OP_PLOT)
              || ((op_r == cskfw_pkg::OP_SPRITE) && !keyed_r));
  assign chg   = wr_ok && (ram_rdata != color_r);

  always_comb begin
    if (cmd.clear) begin
      ram_addr = clr_addr;
    end else if (cmd.look) begin
      ram_addr = lin[ADDR_W-1:0];
    end else begin
      ram_addr = addr_r;
    end
  end

  assign ram_we    = cmd.clear || (cmd.finish && chg);
  assign ram_wdata = cmd.clear ? '0 : color_r;

  cskfw_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // sprite raster position
  assign eff_w    = ((cfg.width == '0) || (cfg.width > cskfw_pkg::SPRITE_DIM_MAX))
                  ? cskfw_pkg::SPRITE_DIM_MAX : cfg.width;
  assign eff_h    = ((cfg.height == '0) || (cfg.height > cskfw_pkg::SPRITE_DIM_MAX))
                  ? cskfw_pkg::SPRITE_DIM_MAX : cfg.height;
  assign col_inc  = {1'b0, col} + 11'd1;
  assign row_inc  = {1'b0, row} + 11'd1;
  assign col_wrap = (col_inc >= eff_w);
  assign row_wrap = (row_inc >= eff_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      col          <= '0;
      row          <= '0;
      update_total <= '0;
      call_total   <= '0;
    end else if (cmd.finish) begin
      update_total <= update_total + 32'(chg);
      call_total   <= call_total + 32'(wr_ok);
      if (op_r == cskfw_pkg::OP_RESTART) begin
        col <= '0;
        row <= '0;
      end else if (op_r == cskfw_pkg::OP_SPRITE) begin
        if (col_wrap) begin
          col <= '0;
          row <= row_wrap ? '0 : row_inc[9:0];
        end else begin
          col <= col_inc[9:0];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      in_frame    <= fin_r && (op_r != cskfw_pkg::OP_RESTART);
      was_keyed   <= keyed_r;
      changed     <= chg;
      sprite_done <= (op_r == cskfw_pkg::OP_SPRITE) && col_wrap && row_wrap;
      read_color  <= ((op_r == cskfw_pkg::OP_READ) && fin_r) ? ram_rdata : '0;
    end
  end

endmodule

@@ rtl/color_keyed_sprite_framebuffer_writer.sv @@
// Color-keyed sprite writer into an RGBA frame store (red in the low byte).
// Each input beat is a plot, a sprite pixel, a read or a sprite restart, and
// gives exactly one result beat. Sprite pixels land at the programmed origin
// plus a raster column and row; a pixel whose RGB matches one of the enabled
// key colors is skipped. In-frame writes bump call_total, and update_total
// when the stored word changes. After reset the frame store is swept to zero,
// one entry per cycle, over all FRAME_WIDTH*FRAME_HEIGHT entries (65536 by
// default); no input beat is taken during the sweep, register writes are. Each
// beat then passes through accept, frame lookup, and compare and write (the
// read-compare-write on the single-port frame memory); the write waits while
// an unclaimed result is held, and no new beat is taken before it. A finished
// result waits in the output register while the next beat is accepted.
module color_keyed_sprite_framebuffer_writer #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256,
  parameter int MAX_KEYS     = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cskfw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cskfw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cskfw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       opcode,
  input  logic signed [11:0]               pos_x,
  input  logic signed [11:0]               pos_y,
  input  logic [7:0]                       red,
  input  logic [7:0]                       green,
  input  logic [7:0]                       blue,
  input  logic [7:0]                       alpha,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             in_frame,
  output logic                             was_keyed,
  output logic                             changed,
  output logic                             sprite_done,
  output logic [31:0]                      read_color,
  output logic [31:0]                      update_total,
  output logic [31:0]                      call_total
);

  cskfw_pkg::cfg_t      cfg;
  cskfw_pkg::ctrl_cmd_t cmd;
  cskfw_pkg::dp_stat_t  stat;

  cskfw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cskfw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cskfw_dp #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .MAX_KEYS     (MAX_KEYS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg          (cfg),
    .opcode       (opcode),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .in_frame     (in_frame),
    .was_keyed    (was_keyed),
    .changed      (changed),
    .sprite_done  (sprite_done),
    .read_color   (read_color),
    .update_total (update_total),
    .call_total   (call_total)
  );

endmodule

@@ tb/sv/sprite_writer_checker.sv @@
module sprite_writer_checker #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256,
  parameter int MAX_KEYS     = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cskfw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cskfw_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                             pready,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [1:0]                       opcode,
  input  logic signed [11:0]               pos_x,
  input  logic signed [11:0]               pos_y,
  input  logic [7:0]                       red,
  input  logic [7:0]                       green,
  input  logic [7:0]                       blue,
  input  logic [7:0]                       alpha,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic                             in_frame,
  input  logic                             was_keyed,
  input  logic                             changed,
  input  logic                             sprite_done,
  input  logic [31:0]                      read_color,
  input  logic [31:0]                      update_total,
  input  logic [31:0]                      call_total,
  output logic                             idle,
  output int                               fails,
  output int                               checked,
  output int                               done_seen,
  output int                               keyed_seen
);

  typedef struct packed {
    logic        in_frame;
    logic        was_keyed;
    logic        changed;
    logic        sprite_done;
    logic [31:0] read_color;
    logic [31:0] update_total;
    logic [31:0] call_total;
  } pixel_result_t;

  bit [31:0]       pixels [FRAME_WIDTH*FRAME_HEIGHT];
  cskfw_pkg::cfg_t cfg;
  int              col;
  int              row;
  bit [31:0]       update_n;
  bit [31:0]       call_n;
  pixel_result_t   owed_results [$];
  int              fail_n;
  int              checked_n;
  int              done_n;
  int              keyed_n;

  assign fails      = fail_n;
  assign checked    = checked_n;
  assign done_seen  = done_n;
  assign keyed_seen = keyed_n;

  function automatic bit on_frame(int x, int y);
    return x >= 0 && x < FRAME_WIDTH && y >= 0 && y < FRAME_HEIGHT;
  endfunction

  function automatic int eff_dim(logic [10:0] d);
    if (d == 11'd0 || d > cskfw_pkg::SPRITE_DIM_MAX) return int'(cskfw_pkg::SPRITE_DIM_MAX);
    return int'(d);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    if (fail_n < 50) $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    fail_n++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report(what, got, want);
  endtask

  task automatic store_pixel(int x, int y, logic [31:0] color, output bit ch);
    int idx;
    idx = y * FRAME_WIDTH + x;
    ch = pixels[idx] != color;
    if (ch) begin
      pixels[idx] = color;
      update_n++;
    end
    call_n++;
  endtask

  task automatic apply_pixel_op(input logic [1:0] op, input int x, input int y,
                                input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic [7:0] a,
                                output pixel_result_t res);
    logic [31:0] color;
    logic [23:0] rgb;
    int          w;
    int          h;
    int          nk;
    int          tx;
    int          ty;
    bit          ch;
    color = {a, b, g, r};
    rgb   = {r, g, b};
    res   = '0;
    ch    = 1'b0;
    case (op)
      cskfw_pkg::OP_PLOT: begin
        res.in_frame = on_frame(x, y);
        if (res.in_frame) store_pixel(x, y, color, ch);
        res.changed = ch;
      end
      cskfw_pkg::OP_SPRITE: begin
        w  = eff_dim(cfg.width);
        h  = eff_dim(cfg.height);
        nk = (cfg.key_count > MAX_KEYS) ? MAX_KEYS : int'(cfg.key_count);
        for (int k = 0; k < cskfw_pkg::NUM_KEY_REGS; k++) begin
          if (k < nk && cfg.keys[k] == rgb) res.was_keyed = 1'b1;
        end
        tx = int'($signed(cfg.origin_x)) + col;
        ty = int'($signed(cfg.origin_y)) + row;
        res.in_frame = on_frame(tx, ty);
        if (res.in_frame && !res.was_keyed) store_pixel(tx, ty, color, ch);
        res.changed = ch;
        if (col + 1 >= w) begin
          col = 0;
          if (row + 1 >= h) begin
            row = 0;
            res.sprite_done = 1'b1;
          end else begin
            row++;
          end
        end else begin
          col++;
        end
      end
      cskfw_pkg::OP_READ: begin
        res.in_frame = on_frame(x, y);
        if (res.in_frame) res.read_color = pixels[y * FRAME_WIDTH + x];
      end
      cskfw_pkg::OP_RESTART: begin
        col = 0;
        row = 0;
      end
      default: ;
    endcase
    res.update_total = update_n;
    res.call_total   = call_n;
  endtask

  always @(posedge clk) begin
    pixel_result_t want;
    pixel_result_t res;
    if (rst) begin
      foreach (pixels[i]) pixels[i] = '0;
      cfg        = '0;
      cfg.width  = 11'd1;
      cfg.height = 11'd1;
      col        = 0;
      row        = 0;
      update_n   = '0;
      call_n     = '0;
      owed_results.delete();
      fail_n     = 0;
      checked_n  = 0;
      done_n     = 0;
      keyed_n    = 0;
      idle      <= 1'b1;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[cskfw_pkg::CFG_ADDR_W-1:2])
          cskfw_pkg::REG_ORIGIN_X:   cfg.origin_x  = pwdata[11:0];
          cskfw_pkg::REG_ORIGIN_Y:   cfg.origin_y  = pwdata[11:0];
          cskfw_pkg::REG_WIDTH:      cfg.width     = pwdata[10:0];
          cskfw_pkg::REG_HEIGHT:     cfg.height    = pwdata[10:0];
          cskfw_pkg::REG_KEY_COUNT:  cfg.key_count = pwdata[1:0];
          cskfw_pkg::REG_KEY_FIRST:  cfg.keys[0]   = pwdata[23:0];
          cskfw_pkg::REG_KEY_SECOND: cfg.keys[1]   = pwdata[23:0];
          cskfw_pkg::REG_KEY_THIRD:  cfg.keys[2]   = pwdata[23:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          report("result beat with nothing owed", call_total, '0);
        end else begin
          want = owed_results.pop_front();
          check_field("in_frame", 32'(in_frame), 32'(want.in_frame));
          check_field("was_keyed", 32'(was_keyed), 32'(want.was_keyed));
          check_field("changed", 32'(changed), 32'(want.changed));
          check_field("sprite_done", 32'(sprite_done), 32'(want.sprite_done));
          check_field("read_color", read_color, want.read_color);
          check_field("update_total", update_total, want.update_total);
          check_field("call_total", call_total, want.call_total);
          checked_n++;
          if (want.sprite_done) done_n++;
          if (want.was_keyed) keyed_n++;
        end
      end
      if (in_valid && !in_stall) begin
        apply_pixel_op(opcode, int'(pos_x), int'(pos_y), red, green, blue, alpha, res);
        owed_results.push_back(res);
      end
      idle <= owed_results.size() == 0;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
module tb;

  localparam int FW = 256;
  localparam int FH = 256;
  localparam int NK = 3;
  localparam int PHASES = 12;
  localparam int PHASE_BEATS = 84;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_RUNS, STALL_HEAVY} stall_mode_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [cskfw_pkg::CFG_ADDR_W-1:0] paddr;
  logic [cskfw_pkg::CFG_DATA_W-1:0] pwdata;
  logic [cskfw_pkg::CFG_DATA_W-1:0] prdata;
  logic                             pready;
  logic                             in_valid;
  logic                             in_stall;
  logic [1:0]                       opcode;
  logic signed [11:0]               pos_x;
  logic signed [11:0]               pos_y;
  logic [7:0]                       red;
  logic [7:0]                       green;
  logic [7:0]                       blue;
  logic [7:0]                       alpha;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             in_frame;
  logic                             was_keyed;
  logic                             changed;
  logic                             sprite_done;
  logic [31:0]                      read_color;
  logic [31:0]                      update_total;
  logic [31:0]                      call_total;

  logic                             idle;
  int                               fails;
  int                               checked;
  int                               done_seen;
  int                               keyed_seen;

  stall_mode_t                      smode = STALL_NONE;
  int                               smode_left = 0;
  int                               srun_left = 0;

  bit                               pace_on;
  int                               burst_left = 0;
  int                               org_x;
  int                               org_y;
  int                               span_w;
  int                               span_h;
  logic [23:0]                      palette [4];

  always #5 clk = ~clk;

  color_keyed_sprite_framebuffer_writer #(
    .FRAME_WIDTH(FW), .FRAME_HEIGHT(FH), .MAX_KEYS(NK)
  ) uut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .opcode, .pos_x, .pos_y, .red, .green, .blue, .alpha,
    .out_valid, .out_stall, .in_frame, .was_keyed, .changed, .sprite_done,
    .read_color, .update_total, .call_total
  );

  sprite_writer_checker #(
    .FRAME_WIDTH(FW), .FRAME_HEIGHT(FH), .MAX_KEYS(NK)
  ) chk (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_stall, .opcode, .pos_x, .pos_y, .red, .green, .blue, .alpha,
    .out_valid, .out_stall, .in_frame, .was_keyed, .changed, .sprite_done,
    .read_color, .update_total, .call_total,
    .idle, .fails, .checked, .done_seen, .keyed_seen
  );

  always @(posedge clk) begin
    if (smode_left == 0) begin
      smode      <= stall_mode_t'($urandom_range(0, 3));
      smode_left <= $urandom_range(40, 300);
    end else begin
      smode_left <= smode_left - 1;
    end
    case (smode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_RUNS: begin
        if (srun_left == 0) begin
          out_stall <= !out_stall;
          srun_left <= $urandom_range(1, 12);
        end else begin
          srun_left <= srun_left - 1;
        end
      end
      default:     out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_regs(int ox, int oy, int w, int h, int kc,
                           logic [23:0] k1, logic [23:0] k2, logic [23:0] k3);
    reg_write(cskfw_pkg::REG_ORIGIN_X, ox);
    reg_write(cskfw_pkg::REG_ORIGIN_Y, oy);
    reg_write(cskfw_pkg::REG_WIDTH, w);
    reg_write(cskfw_pkg::REG_HEIGHT, h);
    reg_write(cskfw_pkg::REG_KEY_COUNT, kc);
    reg_write(cskfw_pkg::REG_KEY_FIRST, {8'h00, k1});
    reg_write(cskfw_pkg::REG_KEY_SECOND, {8'h00, k2});
    reg_write(cskfw_pkg::REG_KEY_THIRD, {8'h00, k3});
    org_x  = ox;
    org_y  = oy;
    span_w = (w == 0 || w > 12) ? 12 : w;
    span_h = (h == 0 || h > 12) ? 12 : h;
  endtask

  task automatic beat(logic [1:0] op, int x, int y, logic [23:0] rgb, logic [7:0] a);
    int gap;
    in_valid <= 1'b1;
    opcode   <= op;
    pos_x    <= x[11:0];
    pos_y    <= y[11:0];
    red      <= rgb[23:16];
    green    <= rgb[15:8];
    blue     <= rgb[7:0];
    alpha    <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = 0;
    if (pace_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
        burst_left = $urandom_range(0, 12);
      end
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (!idle) @(posedge clk);
  endtask

  function automatic int border_coord(int lim);
    case ($urandom_range(0, 3))
      0:       return -1;
      1:       return 0;
      2:       return lim - 1;
      default: return lim;
    endcase
  endfunction

  task automatic random_beat();
    int          sel;
    int          x;
    int          y;
    logic [1:0]  op;
    logic [23:0] rgb;
    logic [7:0]  a;
    sel = $urandom_range(0, 99);
    if (sel < 50) op = cskfw_pkg::OP_SPRITE;
    else if (sel < 70) op = cskfw_pkg::OP_PLOT;
    else if (sel < 95) op = cskfw_pkg::OP_READ;
    else op = cskfw_pkg::OP_RESTART;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      x = $urandom_range(0, 4095);
      y = $urandom_range(0, 4095);
    end else if (sel == 3) begin
      x = border_coord(FW);
      y = border_coord(FH);
    end else begin
      x = org_x + $urandom_range(0, span_w + 1) - 1;
      y = org_y + $urandom_range(0, span_h + 1) - 1;
    end
    if ($urandom_range(0, 9) < 4) rgb = palette[$urandom_range(0, 3)];
    else rgb = 24'($urandom);
    a = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
    beat(op, x, y, rgb, a);
  endtask

  task automatic setup_phase(int ph);
    logic [23:0] k1;
    logic [23:0] k2;
    logic [23:0] k3;
    palette[0] = 24'($urandom);
    palette[1] = 24'($urandom);
    palette[2] = 24'h000000;
    palette[3] = 24'hFFFFFF;
    k1 = palette[$urandom_range(0, 3)];
    k2 = palette[$urandom_range(0, 3)];
    k3 = palette[$urandom_range(0, 3)];
    case (ph)
      0:       load_regs(-2048, 2047, 0, 2047, 3, 24'h000000, 24'hFFFFFF, k3);
      1:       load_regs(2047, -2048, 1024, 1024, 0, k1, k2, k3);
      2:       load_regs(-3, -2, 1, 1024, 1, k1, k2, k3);
      default: load_regs($urandom_range(0, 260) - 4, $urandom_range(0, 260) - 4,
                         $urandom_range(1, 6), $urandom_range(1, 4),
                         $urandom_range(0, 3), k1, k2, k3);
    endcase
    pace_on = (ph % 3) != 0;
  endtask

  initial begin
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    in_valid <= 1'b0;
    opcode   <= cskfw_pkg::OP_PLOT;
    pos_x    <= '0;
    pos_y    <= '0;
    red      <= '0;
    green    <= '0;
    blue     <= '0;
    alpha    <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    pace_on = 1'b1;
    load_regs(254, 254, 3, 2, 2, 24'hFF00FF, 24'h000000, 24'h123456);
    beat(cskfw_pkg::OP_READ, 0, 0, 24'h000000, 8'h00);
    beat(cskfw_pkg::OP_PLOT, 0, 0, 24'h000000, 8'h00);
    beat(cskfw_pkg::OP_PLOT, 0, 0, 24'hFFFFFF, 8'hFF);
    beat(cskfw_pkg::OP_PLOT, FW - 1, FH - 1, 24'h5AA53C, 8'h81);
    beat(cskfw_pkg::OP_PLOT, FW, 0, 24'h112233, 8'h44);
    beat(cskfw_pkg::OP_PLOT, -1, 5, 24'h112233, 8'h44);
    beat(cskfw_pkg::OP_PLOT, -2048, -2048, 24'hFFFFFF, 8'hFF);
    beat(cskfw_pkg::OP_PLOT, 2047, 2047, 24'hFFFFFF, 8'hFF);
    beat(cskfw_pkg::OP_READ, 0, 0, 24'h000000, 8'h00);
    beat(cskfw_pkg::OP_READ, FW - 1, FH - 1, 24'hFFFFFF, 8'hFF);
    beat(cskfw_pkg::OP_READ, -2048, 2047, 24'h000000, 8'h00);
    beat(cskfw_pkg::OP_READ, FW - 1, FH, 24'h000000, 8'h00);
    beat(cskfw_pkg::OP_SPRITE, $urandom, $urandom, 24'hFF00FF, 8'h01);
    beat(cskfw_pkg::OP_SPRITE, $urandom, $urandom, 24'h102030, 8'h40);
    beat(cskfw_pkg::OP_SPRITE, $urandom, $urandom, 24'h010203, 8'hFF);
    beat(cskfw_pkg::OP_SPRITE, $urandom, $urandom, 24'h000000, 8'h80);
    beat(cskfw_pkg::OP_SPRITE, $urandom, $urandom, 24'hABCDEF, 8'h00);
    beat(cskfw_pkg::OP_SPRITE, $urandom, $urandom, 24'h123456, 8'h7F);
    beat(cskfw_pkg::OP_SPRITE, $urandom, $urandom, 24'h123456, 8'h7F);
    beat(cskfw_pkg::OP_RESTART, 2047, -1, 24'hFFFFFF, 8'hFF);
    beat(cskfw_pkg::OP_SPRITE, $urandom, $urandom, 24'h00FF00, 8'hC3);
    beat(cskfw_pkg::OP_READ, 254, 254, 24'h000000, 8'h00);
    beat(cskfw_pkg::OP_READ, 255, 254, 24'h000000, 8'h00);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      setup_phase(ph);
      for (int n = 0; n < PHASE_BEATS; n++) random_beat();
      settle();
    end
    repeat (20) @(posedge clk);

    $display("covered %0d result beats over %0d register settings of plots, reads,",
             checked, PHASES + 1);
    $display("sprite pixels and restarts; %0d sprites completed, %0d pixels keyed out",
             done_seen, keyed_seen);
    if (fails == 0 && idle) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
